### hw/rtl/lbd_pkg.sv
package lbd_pkg;

    localparam int BUTTON_COUNT = 4;
    localparam int ADC_BITS     = 12;

    localparam int RAW_W   = 12;
    localparam int BTN_W   = 5;
    localparam int TIME_W  = 32;
    localparam int HOLD_W  = 16;
    localparam int ERR_W   = 8;
    localparam int AGREE_W = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [RAW_W-1:0] RAW_MASK = RAW_W'((1 << ADC_BITS) - 1);

    localparam logic signed [BTN_W-1:0] BTN_NONE   = -5'sd1;
    localparam logic [ERR_W-1:0]        ERR_MAX    = '1;
    localparam logic [AGREE_W-1:0]      AGREE_MAX  = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COMBO_BAND_LOW  = 3'd0,
        REG_COMBO_BAND_HIGH = 3'd1,
        REG_COMBO_HOLD_MS   = 3'd2,
        REG_ERROR_RUN_LIMIT = 3'd3,
        REG_AGREE_PASSES    = 3'd4
    } cfg_reg_t;

    localparam logic [RAW_W-1:0]   RST_COMBO_BAND_LOW  = 12'd1280;
    localparam logic [RAW_W-1:0]   RST_COMBO_BAND_HIGH = 12'd1390;
    localparam logic [HOLD_W-1:0]  RST_COMBO_HOLD_MS   = 16'd1200;
    localparam logic [ERR_W-1:0]   RST_ERROR_RUN_LIMIT = 8'd10;
    localparam logic [AGREE_W-1:0] RST_AGREE_PASSES    = 4'd3;

    typedef struct packed {
        logic [RAW_W-1:0]   combo_band_low;
        logic [RAW_W-1:0]   combo_band_high;
        logic [HOLD_W-1:0]  combo_hold_ms;
        logic [ERR_W-1:0]   error_run_limit;
        logic [AGREE_W-1:0] agree_passes;
    } cfg_t;

    typedef struct packed {
        logic                    read_ok;
        logic [RAW_W-1:0]        raw_level;
        logic signed [BTN_W-1:0] decoded_button;
        logic [TIME_W-1:0]       time_ms;
    } item_t;

    typedef struct packed {
        logic signed [BTN_W-1:0] committed_button;
        logic                    enter_recovery;
    } result_t;

endpackage

### hw/rtl/ladder_button_debounce_with_combo.sv
// channel | ports                                           | word accepted when
// input   | s_valid/s_ready, s_read_ok, s_raw_level,        | s_valid && s_ready
//         | s_decoded_button, s_time_ms                     |
// result  | m_valid/m_ready, m_committed_button,            | m_valid && m_ready
//         | m_enter_recovery                                |
// config  | cfg_wr_en, cfg_index, cfg_data                  | cfg_wr_en
//
// One word per cycle sustained while m_ready is high; a word passes the input register, then the result register.
// Debounce state updates as a word moves from the input to the result register.
// Result stall holds both registers; a word is taken whenever the input register
// is empty or moving on. Synchronous active-low reset restores register defaults.
module ladder_button_debounce_with_combo
    import lbd_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_read_ok,
    input  logic [RAW_W-1:0]        s_raw_level,
    input  logic signed [BTN_W-1:0] s_decoded_button,
    input  logic [TIME_W-1:0]       s_time_ms,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [BTN_W-1:0] m_committed_button,
    output logic                    m_enter_recovery,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    cfg_t    cfg;
    item_t   item_reg;
    result_t result;
    result_t result_reg;
    logic    in_valid_reg;
    logic    out_valid_reg;
    logic    step;

    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;

    lbd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lbd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (step) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.read_ok        <= s_read_ok;
            item_reg.raw_level      <= s_raw_level;
            item_reg.decoded_button <= s_decoded_button;
            item_reg.time_ms        <= s_time_ms;
        end
        if (step) begin
            result_reg <= result;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_committed_button = result_reg.committed_button;
    assign m_enter_recovery   = result_reg.enter_recovery;

    a_step_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> out_valid_reg)
        else $error("processed word not presented");

    a_pending_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !step |=> in_valid_reg && $stable(item_reg))
        else $error("pending input word lost");

    a_no_step_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> !step)
        else $error("step without an input word");

endmodule

### hw/rtl/lbd_cfg.sv
module lbd_cfg
    import lbd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_COMBO_BAND_LOW:  cfg_next.combo_band_low  = cfg_data[RAW_W-1:0];
                REG_COMBO_BAND_HIGH: cfg_next.combo_band_high = cfg_data[RAW_W-1:0];
                REG_COMBO_HOLD_MS:   cfg_next.combo_hold_ms   = cfg_data[HOLD_W-1:0];
                REG_ERROR_RUN_LIMIT: cfg_next.error_run_limit = cfg_data[ERR_W-1:0];
                REG_AGREE_PASSES:    cfg_next.agree_passes    = cfg_data[AGREE_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.combo_band_low  <= RST_COMBO_BAND_LOW;
            cfg_reg.combo_band_high <= RST_COMBO_BAND_HIGH;
            cfg_reg.combo_hold_ms   <= RST_COMBO_HOLD_MS;
            cfg_reg.error_run_limit <= RST_ERROR_RUN_LIMIT;
            cfg_reg.agree_passes    <= RST_AGREE_PASSES;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/lbd_core.sv
module lbd_core
    import lbd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    logic signed [BTN_W-1:0] committed_reg, committed_next;
    logic signed [BTN_W-1:0] candidate_reg, candidate_next;
    logic [AGREE_W-1:0]      agree_reg, agree_next;
    logic                    combo_timing_reg, combo_timing_next;
    logic [TIME_W-1:0]       combo_start_reg, combo_start_next;
    logic [ERR_W-1:0]        err_run_reg, err_run_next;

    logic [RAW_W-1:0]        raw;
    logic                    in_band;
    logic [TIME_W-1:0]       held;
    logic signed [BTN_W-1:0] dec;
    logic [ERR_W-1:0]        err_inc;
    logic [AGREE_W-1:0]      agree_inc;
    logic                    recover;

    assign raw     = item.raw_level & RAW_MASK;
    assign in_band = (raw >= cfg.combo_band_low) && (raw <= cfg.combo_band_high);
    assign held    = item.time_ms - combo_start_reg;
    assign dec     = (!item.decoded_button[BTN_W-1] &&
                      item.decoded_button[AGREE_W-1:0] < AGREE_W'(BUTTON_COUNT))
                     ? item.decoded_button : BTN_NONE;
    assign err_inc   = (err_run_reg == ERR_MAX) ? err_run_reg : err_run_reg + 1'b1;
    assign agree_inc = (agree_reg == AGREE_MAX) ? agree_reg : agree_reg + 1'b1;

    always_comb begin
        committed_next    = committed_reg;
        candidate_next    = candidate_reg;
        agree_next        = agree_reg;
        combo_timing_next = combo_timing_reg;
        combo_start_next  = combo_start_reg;
        err_run_next      = err_run_reg;
        recover           = 1'b0;
        if (!item.read_ok) begin
            err_run_next = err_inc;
            if (err_inc >= cfg.error_run_limit) begin
                committed_next    = BTN_NONE;
                candidate_next    = BTN_NONE;
                agree_next        = '0;
                combo_timing_next = 1'b0;
            end
        end else begin
            err_run_next = '0;
            if (in_band) begin
                if (!combo_timing_reg) begin
                    combo_timing_next = 1'b1;
                    combo_start_next  = item.time_ms;
                end else if (held >= TIME_W'(cfg.combo_hold_ms)) begin
                    recover = 1'b1;
                end
                committed_next = BTN_NONE;
                candidate_next = BTN_NONE;
                agree_next     = '0;
            end else begin
                combo_timing_next = 1'b0;
                priority if (dec == committed_reg) begin
                    agree_next = '0;
                end else if (dec == candidate_reg) begin
                    if (agree_inc >= cfg.agree_passes) begin
                        committed_next = dec;
                        agree_next     = '0;
                    end else begin
                        agree_next = agree_inc;
                    end
                end else begin
                    candidate_next = dec;
                    agree_next     = AGREE_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            committed_reg    <= BTN_NONE;
            candidate_reg    <= BTN_NONE;
            agree_reg        <= '0;
            combo_timing_reg <= 1'b0;
            combo_start_reg  <= '0;
            err_run_reg      <= '0;
        end else if (step) begin
            committed_reg    <= committed_next;
            candidate_reg    <= candidate_next;
            agree_reg        <= agree_next;
            combo_timing_reg <= combo_timing_next;
            combo_start_reg  <= combo_start_next;
            err_run_reg      <= err_run_next;
        end
    end

    assign result.committed_button = committed_next;
    assign result.enter_recovery   = recover;

    a_recover_needs_timing: assert property (@(posedge aclk) disable iff (!aresetn)
        step && recover |-> combo_timing_reg)
        else $error("recovery flagged outside a timed combo");

    a_recover_clears_button: assert property (@(posedge aclk) disable iff (!aresetn)
        step && recover |=> committed_reg == BTN_NONE && agree_reg == '0)
        else $error("button state kept during recovery");

    a_error_limit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !item.read_ok && err_inc >= cfg.error_run_limit
        |=> committed_reg == BTN_NONE && !combo_timing_reg)
        else $error("state not cleared at error run limit");

    a_commit_resets_counter: assert property (@(posedge aclk) disable iff (!aresetn)
        step && committed_next != committed_reg |=> agree_reg == '0)
        else $error("agree counter not cleared on commit");

endmodule
